// ===== rtl/rial_pkg.sv =====
// ----------------------------------------------------------------------------
// rial_pkg
// Shared types and constants for the recycling id allocator with tags.
// ----------------------------------------------------------------------------
`default_nettype none

package rial_pkg;

    // Sizing
    localparam int ID_LIMIT   = 255;
    localparam int TAG_BITS   = 32;
    localparam int ID_W       = 8;
    localparam int TAG_PORT_W = 32;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = ID_W + 1;
    localparam int NUM_IDS    = 1 << ID_W;

    // Fresh ids run from zero up to this bound, exclusive
    localparam int FRESH_CAP  = (ID_LIMIT < NUM_IDS - 1) ? ID_LIMIT : NUM_IDS - 1;

    typedef logic [ID_W-1:0]       id_t;
    typedef logic [TAG_BITS-1:0]   tag_t;
    typedef logic [TAG_PORT_W-1:0] tag_port_t;
    typedef logic [FUNC_W-1:0]     func_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [FILL_W-1:0]     fill_t;

    // Operation codes
    localparam func_t FUNC_CREATE  = 3'd0;
    localparam func_t FUNC_DESTROY = 3'd1;
    localparam func_t FUNC_QUERY   = 3'd2;
    localparam func_t FUNC_SET_TAG = 3'd3;
    localparam func_t FUNC_GET_TAG = 3'd4;

    // Status codes
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_RANGE     = 2'd1;
    localparam status_t STATUS_EXHAUSTED = 2'd2;
    localparam status_t STATUS_DBL_FREE  = 2'd3;

    // One result item
    typedef struct packed {
        id_t       id_out;
        tag_port_t tag_out;
        logic      exists;
        status_t   status;
        id_t       live_count;
    } rial_res_t;

    // Memory write commands from the control logic
    typedef struct packed {
        logic fq_we;
        id_t  fq_waddr;
        id_t  fq_wdata;
        logic tag_we;
        id_t  tag_waddr;
        tag_t tag_wdata;
        logic map_we;
        id_t  map_waddr;
        logic map_wdata;
    } rial_mem_wr_t;

endpackage : rial_pkg

`default_nettype wire

// ===== rtl/rial_ram.sv =====
// ----------------------------------------------------------------------------
// rial_ram
// Single write port, single read port RAM with registered read data and
// write-to-read bypass on a same-cycle address match.
// ----------------------------------------------------------------------------
`default_nettype none

module rial_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, new data wins on a collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule : rial_ram

`default_nettype wire

// ===== rtl/rial_core.sv =====
// ----------------------------------------------------------------------------
// rial_core
// Allocator state (queue pointers, fresh counter, live count) and the
// single-pass decision logic for the item held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module rial_core
    import rial_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         commit,
    input  wire func_t        s1_func,
    input  wire id_t          s1_id,
    input  wire tag_port_t    s1_tag,
    input  wire id_t          fq_rdata,
    input  wire tag_t         tag_rdata,
    input  wire logic         map_rdata,
    output rial_res_t         res,
    output rial_mem_wr_t      wr,
    output id_t               fq_raddr
);

    id_t                head_reg, head_next;
    id_t                tail_reg, tail_next;
    fill_t              fill_reg, fill_next;
    fill_t              fresh_reg, fresh_next;
    id_t                live_reg, live_next;

    logic               in_range;
    rial_mem_wr_t       wr_raw;

    assign in_range = {1'b0, s1_id} < fresh_reg;

    // Decide the item
    always_comb
    begin
        res        = '0;
        wr_raw     = '0;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        fresh_next = fresh_reg;
        live_next  = live_reg;

        unique case (s1_func)
            FUNC_CREATE:
            begin
                priority if (fill_reg != '0)
                begin
                    res.id_out = fq_rdata;
                    head_next  = head_reg + 1'b1;
                    fill_next  = fill_reg - 1'b1;
                end
                else if (fresh_reg < FILL_W'(FRESH_CAP))
                begin
                    res.id_out       = fresh_reg[ID_W-1:0];
                    wr_raw.tag_we    = 1'b1;
                    wr_raw.tag_waddr = fresh_reg[ID_W-1:0];
                    wr_raw.tag_wdata = '0;
                    fresh_next       = fresh_reg + 1'b1;
                end
                else
                begin
                    res.status = STATUS_EXHAUSTED;
                end
                if (res.status == STATUS_OK)
                begin
                    wr_raw.map_we    = 1'b1;
                    wr_raw.map_waddr = res.id_out;
                    wr_raw.map_wdata = 1'b1;
                    live_next        = live_reg + 1'b1;
                end
            end
            FUNC_DESTROY:
            begin
                priority if (!in_range)
                begin
                    res.status = STATUS_RANGE;
                end
                else if (!map_rdata)
                begin
                    res.status = STATUS_DBL_FREE;
                end
                else
                begin
                    wr_raw.tag_we    = 1'b1;
                    wr_raw.tag_waddr = s1_id;
                    wr_raw.tag_wdata = '0;
                    wr_raw.fq_we     = 1'b1;
                    wr_raw.fq_waddr  = tail_reg;
                    wr_raw.fq_wdata  = s1_id;
                    wr_raw.map_we    = 1'b1;
                    wr_raw.map_waddr = s1_id;
                    wr_raw.map_wdata = 1'b0;
                    tail_next        = tail_reg + 1'b1;
                    fill_next        = fill_reg + 1'b1;
                    live_next        = live_reg - 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                if (!in_range)
                begin
                    res.status = STATUS_RANGE;
                end
                else
                begin
                    res.exists = map_rdata;
                end
            end
            FUNC_SET_TAG:
            begin
                if (!in_range)
                begin
                    res.status = STATUS_RANGE;
                end
                else
                begin
                    wr_raw.tag_we    = 1'b1;
                    wr_raw.tag_waddr = s1_id;
                    wr_raw.tag_wdata = TAG_BITS'(s1_tag);
                end
            end
            FUNC_GET_TAG:
            begin
                if (!in_range)
                begin
                    res.status = STATUS_RANGE;
                end
                else
                begin
                    res.tag_out = TAG_PORT_W'(tag_rdata);
                end
            end
            default:
            begin
                // unused codes: no operation
            end
        endcase

        res.live_count = live_next;
    end

    // Writes only land when the item moves on
    always_comb
    begin
        wr        = wr_raw;
        wr.fq_we  = wr_raw.fq_we && commit;
        wr.tag_we = wr_raw.tag_we && commit;
        wr.map_we = wr_raw.map_we && commit;
    end

    // Queue read always follows the head the next item will see
    assign fq_raddr = commit ? head_next : head_reg;

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            fresh_reg <= '0;
            live_reg  <= '0;
        end
        else if (commit)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            fresh_reg <= fresh_next;
            live_reg  <= live_next;
        end
    end

    // Every id made so far is either live or waiting in the queue
    a_ids_accounted: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, live_reg} + fill_reg) == fresh_reg)
        else $error("live count plus queue fill differs from ids made");

    // Fresh counter never passes its bound
    a_fresh_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= FILL_W'(FRESH_CAP))
        else $error("fresh counter beyond its bound");

    // Queue pointers agree with the fill level
    a_queue_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        ID_W'(tail_reg - head_reg) == fill_reg[ID_W-1:0])
        else $error("queue pointers disagree with fill level");

    // Exhaustion is only reported when nothing is left to hand out
    a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && res.status == STATUS_EXHAUSTED) |->
            (fill_reg == '0 && fresh_reg == FILL_W'(FRESH_CAP)))
        else $error("exhausted reported while ids remain");

endmodule : rial_core

`default_nettype wire

// ===== rtl/recycling_id_allocator_with_tags_top.sv =====
// ----------------------------------------------------------------------------
// recycling_id_allocator_with_tags_top
// Id allocator with FIFO recycling of freed ids and a per-id signature tag.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  -------------------------------------------
//  in       in_valid / in_stall  func, entity_id, tag_in
//  out      out_valid/out_stall  id_out, tag_out, exists, status, live_count
//
//  One item per cycle sustained while out_stall is low; an accepted item is
//  held in the input register until it commits, and its result is then
//  registered in the result register and presented from there.
//  Tag and live-map RAMs are read as the item transfers in, the free queue
//  every cycle; each bypasses the write made by the item deciding at that edge.
//  Reset clears the control state only; a tag or live-map entry is written
//  when its id is first made, before any read of it is used. No clearing pass.
//  in_stall rises only when both registers are full and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module recycling_id_allocator_with_tags_top
    import rial_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire func_t     func,
    input  wire id_t       entity_id,
    input  wire tag_port_t tag_in,
    output logic           out_valid,
    input  wire logic      out_stall,
    output id_t            id_out,
    output tag_port_t      tag_out,
    output logic           exists,
    output status_t        status,
    output id_t            live_count
);

    logic         s1_valid_reg;
    func_t        s1_func_reg;
    id_t          s1_id_reg;
    tag_port_t    s1_tag_reg;
    logic         out_valid_reg;
    rial_res_t    out_reg;

    logic         out_free;
    logic         commit;
    logic         accept;
    rial_res_t    res;
    rial_mem_wr_t wr;
    id_t          fq_raddr;
    id_t          fq_rdata;
    tag_t         tag_rdata;
    logic         map_rdata;

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !out_free);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= func;
            s1_id_reg   <= entity_id;
            s1_tag_reg  <= tag_in;
        end
    end

    // Free queue storage
    rial_ram #(
        .ADDR_W (ID_W),
        .DATA_W (ID_W)
    ) u_fq_ram (
        .clk   (clk),
        .we    (wr.fq_we),
        .waddr (wr.fq_waddr),
        .wdata (wr.fq_wdata),
        .re    (1'b1),
        .raddr (fq_raddr),
        .rdata (fq_rdata)
    );

    // Tag table, read as the item transfers in
    rial_ram #(
        .ADDR_W (ID_W),
        .DATA_W (TAG_BITS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (wr.tag_we),
        .waddr (wr.tag_waddr),
        .wdata (wr.tag_wdata),
        .re    (accept),
        .raddr (entity_id),
        .rdata (tag_rdata)
    );

    // Live map, read as the item transfers in
    rial_ram #(
        .ADDR_W (ID_W),
        .DATA_W (1)
    ) u_map_ram (
        .clk   (clk),
        .we    (wr.map_we),
        .waddr (wr.map_waddr),
        .wdata (wr.map_wdata),
        .re    (accept),
        .raddr (entity_id),
        .rdata (map_rdata)
    );

    // Decision logic and allocator state
    rial_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .s1_func   (s1_func_reg),
        .s1_id     (s1_id_reg),
        .s1_tag    (s1_tag_reg),
        .fq_rdata  (fq_rdata),
        .tag_rdata (tag_rdata),
        .map_rdata (map_rdata),
        .res       (res),
        .wr        (wr),
        .fq_raddr  (fq_raddr)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= commit || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign id_out     = out_reg.id_out;
    assign tag_out    = out_reg.tag_out;
    assign exists     = out_reg.exists;
    assign status     = out_reg.status;
    assign live_count = out_reg.live_count;

endmodule : recycling_id_allocator_with_tags_top

`default_nettype wire
